// ===== src/rtq_pkg.sv =====
// ----------------------------------------------------------------------------
// rtq_pkg
// Types, constants and calendar helpers for the radio time qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rtq_pkg;

    localparam int unsigned CfgDataWidth  = 16;
    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [7:0]  StatusAbsent      = 8'hFF;
    localparam logic [7:0]  CenturyPivot      = 8'd90;
    localparam logic [11:0] Year1900          = 12'd1900;
    localparam logic [11:0] Year2000          = 12'd2000;
    localparam logic [7:0]  HourMax           = 8'd23;
    localparam logic [7:0]  HoursPerDay       = 8'd24;
    localparam logic [7:0]  MonthsPerYear     = 8'd12;
    localparam logic [7:0]  MinuteMax         = 8'd59;
    localparam logic [7:0]  MatchMax          = 8'd255;
    localparam logic [14:0] SetCountMax       = 15'd32767;
    localparam logic [7:0]  RepeatRequiredRst = 8'd2;
    localparam logic [15:0] SetIntervalRst    = 16'd60;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_UTC_MODE        = 2'd0,
        CFG_HOUR_OFFSET     = 2'd1,
        CFG_REPEAT_REQUIRED = 2'd2,
        CFG_SET_INTERVAL    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  status_byte;
        logic [7:0]  bcd_hour;
        logic [7:0]  bcd_minute;
        logic [7:0]  bcd_second;
        logic [7:0]  bcd_day;
        logic [7:0]  bcd_month;
        logic [7:0]  bcd_year;
        logic        set_accepted;
    } rtq_item_t;

    typedef struct packed {
        logic        time_valid;
        logic [4:0]  hour_out;
        logic [6:0]  minute_out;
        logic [6:0]  second_out;
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [11:0] year_out;
        logic        clock_written;
        logic [14:0] sets_total;
    } rtq_result_t;

    typedef struct packed {
        logic              utc_mode;
        logic signed [2:0] hour_offset;
        logic [7:0]        repeat_required;
        logic [15:0]       set_interval;
    } rtq_cfg_t;

    typedef struct packed {
        logic [7:0]  match_count;
        logic [5:0]  expected_minute;
        logic [4:0]  expected_hour;
        logic [5:0]  expected_day;
        logic [3:0]  expected_month;
        logic [11:0] expected_year;
        logic [15:0] interval_count;
        logic [14:0] set_count;
    } rtq_state_t;

    // Two BCD nibbles, each taken at face value 0..15
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

    // Years stay within 1990..2091, where the only century year (2000) is
    // also a leap year, so divisibility by four decides.
    function automatic logic [4:0] month_days(input logic [7:0] mo, input logic leap);
        logic [4:0] days;
        if (mo == 8'd2) begin
            days = leap ? 5'd29 : 5'd28;
        end else if (mo inside {8'd4, 8'd6, 8'd9, 8'd11}) begin
            days = 5'd30;
        end else begin
            days = 5'd31;
        end
        return days;
    endfunction

endpackage

`default_nettype wire

// ===== src/rtq_step.sv =====
// ----------------------------------------------------------------------------
// rtq_step
// Per-item logic: reading decode, calendar adjust, match test, tick gating.
// ----------------------------------------------------------------------------
`default_nettype none

module rtq_step
    import rtq_pkg::*;
(
    input  wire rtq_item_t  item,
    input  wire rtq_cfg_t   cfg,
    input  wire rtq_state_t state,
    output rtq_result_t     result,
    output rtq_state_t      state_next
);

    logic        rd_ok;
    logic [7:0]  h_bin, min_bin, sec_bin, d_bin, mo_bin, y_bin;
    logic [11:0] y_base;
    logic [1:0]  zone;
    logic [3:0]  off;
    logic [8:0]  h0;
    logic        h_over, h_under;
    logic [4:0]  md_up, md_dn;
    logic [7:0]  d_inc, mo_inc, mo_dec;
    logic [11:0] y_dec;
    logic [7:0]  h_adj, d_adj, mo_adj;
    logic [11:0] y_adj;
    logic        hit;
    logic [7:0]  nm, nh, nd;

    logic        qualify;
    logic [15:0] ic_inc;
    logic        interval_due;
    logic        take;
    logic        valid;
    logic [7:0]  mc_base;

    always_comb
    begin
        rd_ok   = item.status_byte[0] && (item.status_byte != StatusAbsent);
        h_bin   = bcd_to_bin(item.bcd_hour);
        min_bin = bcd_to_bin(item.bcd_minute);
        sec_bin = bcd_to_bin(item.bcd_second);
        d_bin   = bcd_to_bin(item.bcd_day);
        mo_bin  = bcd_to_bin(item.bcd_month);
        y_bin   = bcd_to_bin(item.bcd_year);
        y_base  = ((y_bin > CenturyPivot) ? Year1900 : Year2000) + {4'd0, y_bin};

        zone = cfg.utc_mode ? {item.status_byte[2], item.status_byte[1]} : 2'd0;
        off  = {cfg.hour_offset[2], cfg.hour_offset} - {2'd0, zone};
        // 9-bit two's complement hour, -7..168
        h0      = {1'b0, h_bin} + {{5{off[3]}}, off};
        h_over  = !h0[8] && (h0[7:0] > HourMax);
        h_under = h0[8];

        md_up  = month_days(mo_bin, y_base[1:0] == 2'd0);
        d_inc  = d_bin + 8'd1;
        mo_inc = mo_bin + 8'd1;

        if (mo_bin == 8'd1) begin
            mo_dec = MonthsPerYear;
        end else if (mo_bin == 8'd0) begin
            mo_dec = MonthsPerYear - 8'd1;
        end else begin
            mo_dec = mo_bin - 8'd1;
        end
        y_dec = (mo_bin <= 8'd1) ? (y_base - 12'd1) : y_base;
        md_dn = month_days(mo_dec, y_dec[1:0] == 2'd0);

        h_adj  = h0[7:0];
        d_adj  = d_bin;
        mo_adj = mo_bin;
        y_adj  = y_base;
        if (h_over) begin
            h_adj = h0[7:0] - HoursPerDay;
            d_adj = d_inc;
            if (d_inc > {3'd0, md_up}) begin
                d_adj  = d_inc - {3'd0, md_up};
                mo_adj = mo_inc;
                if (mo_inc > MonthsPerYear) begin
                    mo_adj = mo_inc - MonthsPerYear;
                    y_adj  = y_base + 12'd1;
                end
            end
        end else if (h_under) begin
            h_adj = h0[7:0] + HoursPerDay;
            // day 0 or 1 steps back into the previous month
            if (d_bin <= 8'd1) begin
                mo_adj = mo_dec;
                y_adj  = y_dec;
                d_adj  = {3'd0, md_dn};
            end else begin
                d_adj = d_bin - 8'd1;
            end
        end

        hit = (min_bin[5:0] == state.expected_minute) &&
              (h_adj[4:0] == state.expected_hour) &&
              (d_adj[5:0] == state.expected_day) &&
              (mo_adj[3:0] == state.expected_month) &&
              (y_adj == state.expected_year);

        // next expected minute; day is not wrapped at month end
        nm = min_bin + 8'd1;
        nh = h_adj;
        nd = d_adj;
        if (nm > MinuteMax) begin
            nm = 8'd0;
            nh = h_adj + 8'd1;
        end
        if (nh == HoursPerDay) begin
            nh = 8'd0;
            nd = d_adj + 8'd1;
        end

        qualify      = cfg.repeat_required <= state.match_count;
        ic_inc       = state.interval_count + 16'd1;
        interval_due = ic_inc >= cfg.set_interval;
        take         = !item.cmd || (qualify && interval_due);
        valid        = take && rd_ok;
        mc_base      = (item.cmd && qualify) ? cfg.repeat_required : state.match_count;

        state_next = state;
        state_next.match_count = mc_base;
        if (valid) begin
            if (!hit) begin
                state_next.match_count = 8'd0;
            end else if (mc_base != MatchMax) begin
                state_next.match_count = mc_base + 8'd1;
            end
            state_next.expected_minute = nm[5:0];
            state_next.expected_hour   = nh[4:0];
            state_next.expected_day    = nd[5:0];
            state_next.expected_month  = mo_adj[3:0];
            state_next.expected_year   = y_adj;
        end

        result = '0;
        if (item.cmd && qualify) begin
            state_next.interval_count = ic_inc;
            if (interval_due) begin
                if (valid && item.set_accepted) begin
                    state_next.interval_count = 16'd0;
                    result.clock_written      = 1'b1;
                    if (state.set_count != SetCountMax) begin
                        state_next.set_count = state.set_count + 15'd1;
                    end
                end else begin
                    state_next.interval_count = cfg.set_interval - 16'd1;
                end
            end
        end

        if (valid) begin
            result.time_valid = 1'b1;
            result.hour_out   = h_adj[4:0];
            result.minute_out = min_bin[6:0];
            result.second_out = sec_bin[6:0];
            result.day_out    = d_adj[4:0];
            result.month_out  = mo_adj[3:0];
            result.year_out   = y_adj;
        end
        result.sets_total = state_next.set_count;
    end

endmodule

`default_nettype wire

// ===== src/radio_time_qualifier_and_setter_top.sv =====
// ----------------------------------------------------------------------------
// radio_time_qualifier_and_setter_top
// Qualifies radio clock readings and decides when to set the system clock.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): one read or tick per item,
//   carrying the receiver status byte and BCD time registers.
//   result channel (result_valid/result_ready/result): exactly one result
//   per item, in order.
//   cfg_we/cfg_index/cfg_data: single-cycle register writes; the user must
//   make them only while the block is idle, which the block does not enforce.
// An accepted item is held in an input register, then the decode/calendar/match
// logic writes the result register.
// Throughput is one item per cycle unless result_ready stalls; the match and
// interval state is updated in the same cycle that the result register is
// loaded, so back-to-back items see each other's effects.
// When result_ready is low the result register holds and one more item
// may wait in the input register; item_ready then drops.
// Reset clears all counters and predictions, sets repeat_required to 2,
// set_interval to 60, utc_mode and hour_offset to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_time_qualifier_and_setter_top
    import rtq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_ready,
    input  wire rtq_item_t                item,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output rtq_result_t                   result,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data
);

    rtq_item_t   item_reg;
    logic        item_valid_reg;
    rtq_result_t result_reg;
    logic        result_valid_reg;
    rtq_cfg_t    cfg_reg;
    rtq_state_t  state_reg;
    rtq_state_t  state_next;
    rtq_result_t result_next;
    logic        advance;

    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    rtq_step u_step (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end else begin
            if (item_ready) begin
                item_valid_reg <= item_valid;
            end
            if (advance) begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end else if (result_ready) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready) begin
            item_reg <= item;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.utc_mode        <= 1'b0;
            cfg_reg.hour_offset     <= 3'sd0;
            cfg_reg.repeat_required <= RepeatRequiredRst;
            cfg_reg.set_interval    <= SetIntervalRst;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_UTC_MODE:        cfg_reg.utc_mode        <= cfg_data[0];
                CFG_HOUR_OFFSET:     cfg_reg.hour_offset     <= $signed(cfg_data[2:0]);
                CFG_REPEAT_REQUIRED: cfg_reg.repeat_required <= cfg_data[7:0];
                CFG_SET_INTERVAL:    cfg_reg.set_interval    <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire
